// ===== hw/rtl/otabsa_pkg.sv =====
// Shared types, constants and the CRC step for the download data block section assembler.
package otabsa_pkg;

    // Sizing of the block bitmap and of the image buffer.
    localparam int MAX_BLOCKS   = 1024;
    localparam int BLOCK_STRIDE = 4062;
    localparam int BLK_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int POS_W        = 13;
    localparam int LEN_W        = 12;
    localparam int ADDR_W       = 22;
    localparam int STAT_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // Section framing.
    localparam int               HDR_BYTES = 30;
    localparam logic [7:0]       TABLE_DDB = 8'h3C;
    localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
    localparam logic [31:0]      CRC_POLY  = 32'h04C1_1DB7;
    localparam logic [31:0]      CRC_INIT  = 32'hFFFF_FFFF;

    // Status codes reported on the final byte of a section.
    localparam logic [STAT_W-1:0] STAT_STORED   = 4'd0;
    localparam logic [STAT_W-1:0] STAT_COMPLETE = 4'd1;
    localparam logic [STAT_W-1:0] STAT_TABLE    = 4'd2;
    localparam logic [STAT_W-1:0] STAT_LENGTH   = 4'd3;
    localparam logic [STAT_W-1:0] STAT_CRC      = 4'd4;
    localparam logic [STAT_W-1:0] STAT_GRPMOD   = 4'd5;
    localparam logic [STAT_W-1:0] STAT_VERSION  = 4'd6;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 4'd7;
    localparam logic [STAT_W-1:0] STAT_DUP      = 4'd8;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 4'd9;
    localparam logic [STAT_W-1:0] STAT_TOO_MANY = 4'd10;
    localparam logic [STAT_W-1:0] STAT_NONE     = 4'd0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd2;

    // Expected header values held in the configuration registers.
    typedef struct packed {
        logic [7:0]  group_id;
        logic [7:0]  module_id;
        logic [15:0] version;
    } cfg_t;

    // One result transaction.
    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        write_data;
        logic              section_done;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  blocks_done;
        logic [CNT_W-1:0]  blocks_total;
        logic [ADDR_W-1:0] image_size;
    } res_t;

    // One byte of CRC-32/MPEG-2, most significant bit first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {data, 24'h000000};
        for (int i = 0; i < 8; i++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/ota_block_section_assembler.sv =====
// Top level of the download data block section assembler.
// Each result is registered in the output stage, via the skid register while m_ready is low.
// Throughput: one section byte per cycle while s_ready is high, set by the bitmap check path.
// A start command is answered at once, then a bitmap clearing pass holds s_ready low.
// Reset (aresetn, synchronous, active low) clears all control state and runs the same
// clearing pass before the first transaction is accepted.
module ota_block_section_assembler (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [7:0]                          s_section_byte,
    input  logic                                s_last_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_write_enable,
    output logic [otabsa_pkg::ADDR_W-1:0]       m_write_address,
    output logic [7:0]                          m_write_data,
    output logic                                m_section_done,
    output logic [otabsa_pkg::STAT_W-1:0]       m_status,
    output logic [otabsa_pkg::CNT_W-1:0]        m_blocks_done,
    output logic [otabsa_pkg::CNT_W-1:0]        m_blocks_total,
    output logic [otabsa_pkg::ADDR_W-1:0]       m_image_size,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [otabsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [otabsa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    otabsa_pkg::cfg_t cfg_reg;
    otabsa_pkg::res_t ctrl_res;
    otabsa_pkg::res_t out_res;
    logic             running;
    logic             skid_ready;
    logic             in_accept;

    // Configuration registers; a write to an unknown index is ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                otabsa_pkg::CFG_GROUP:   cfg_reg.group_id  <= cfg_data[7:0];
                otabsa_pkg::CFG_MODULE:  cfg_reg.module_id <= cfg_data[7:0];
                otabsa_pkg::CFG_VERSION: cfg_reg.version   <= cfg_data[15:0];
                default:                 ;
            endcase
        end
    end

    // Input transactions are taken while the bitmap is usable and the skid stage has room.
    assign s_ready   = running && skid_ready;
    assign in_accept = s_valid && s_ready;

    otabsa_section_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_accept (in_accept),
        .in_cmd    (s_cmd),
        .in_byte   (s_section_byte),
        .in_last   (s_last_byte),
        .running   (running),
        .res       (ctrl_res)
    );

    otabsa_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_accept),
        .in_ready  (skid_ready),
        .in_data   (ctrl_res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    // Result fields.
    assign m_write_enable  = out_res.write_enable;
    assign m_write_address = out_res.write_address;
    assign m_write_data    = out_res.write_data;
    assign m_section_done  = out_res.section_done;
    assign m_status        = out_res.status;
    assign m_blocks_done   = out_res.blocks_done;
    assign m_blocks_total  = out_res.blocks_total;
    assign m_image_size    = out_res.image_size;

endmodule

// ===== hw/rtl/otabsa_bitmap_ram.sv =====
// Block bitmap: one bit per block, one write and one registered read port.
module otabsa_bitmap_ram (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [otabsa_pkg::BLK_W-1:0] wr_addr,
    input  logic                        wr_bit,
    input  logic [otabsa_pkg::BLK_W-1:0] rd_addr,
    output logic                        rd_bit
);

    logic mem [otabsa_pkg::MAX_BLOCKS];
    logic rd_bit_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_bit;
        end
    end

    // Read port; a write to the same entry in the same cycle is forwarded.
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_bit_reg <= wr_bit;
        end else begin
            rd_bit_reg <= mem[rd_addr];
        end
    end

    assign rd_bit = rd_bit_reg;

endmodule

// ===== hw/rtl/otabsa_section_ctrl.sv =====
// Section parser, checks, session counters and bitmap clearing sequencer.
module otabsa_section_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  otabsa_pkg::cfg_t     cfg,
    input  logic                 in_accept,
    input  logic                 in_cmd,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output logic                 running,
    output otabsa_pkg::res_t     res
);

    // Sequencer codes.
    localparam logic CTL_CLEAR = 1'b0;
    localparam logic CTL_RUN   = 1'b1;

    // Header byte offsets within a section.
    localparam logic [otabsa_pkg::POS_W-1:0] OFS_TABLE   = 13'd0;
    localparam logic [otabsa_pkg::POS_W-1:0] OFS_LEN_HI  = 13'd1;
    localparam logic [otabsa_pkg::POS_W-1:0] OFS_LEN_LO  = 13'd2;
    localparam logic [otabsa_pkg::POS_W-1:0] OFS_MODULE  = 13'd4;
    localparam logic [otabsa_pkg::POS_W-1:0] OFS_BLK_HI  = 13'd6;
    localparam logic [otabsa_pkg::POS_W-1:0] OFS_BLK_LO  = 13'd7;
    localparam logic [otabsa_pkg::POS_W-1:0] OFS_GROUP   = 13'd12;
    localparam logic [otabsa_pkg::POS_W-1:0] OFS_VER_HI  = 13'd14;
    localparam logic [otabsa_pkg::POS_W-1:0] OFS_VER_LO  = 13'd15;
    localparam logic [otabsa_pkg::POS_W-1:0] OFS_TOT_HI  = 13'd28;
    localparam logic [otabsa_pkg::POS_W-1:0] OFS_TOT_LO  = 13'd29;
    localparam logic [otabsa_pkg::POS_W-1:0] OFS_PAYLOAD = otabsa_pkg::POS_W'(otabsa_pkg::HDR_BYTES);

    // Length limits: header plus CRC overhead and the largest payload per block.
    localparam logic [otabsa_pkg::LEN_W-1:0] LEN_EMPTY_MAX = 12'd31;
    localparam logic [otabsa_pkg::LEN_W-1:0] LEN_STRIDE    =
        otabsa_pkg::LEN_W'(otabsa_pkg::BLOCK_STRIDE);

    localparam int BLK_W  = otabsa_pkg::BLK_W;
    localparam int CNT_W  = otabsa_pkg::CNT_W;
    localparam int POS_W  = otabsa_pkg::POS_W;
    localparam int LEN_W  = otabsa_pkg::LEN_W;
    localparam int ADDR_W = otabsa_pkg::ADDR_W;
    localparam int STAT_W = otabsa_pkg::STAT_W;

    // Control and section state.
    logic                 state_reg, state_next;
    logic [BLK_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [LEN_W-1:0]     dl_reg, dl_next;
    logic [7:0]           hg_reg, hg_next;
    logic [7:0]           hm_reg, hm_next;
    logic [15:0]          hv_reg, hv_next;
    logic [15:0]          hb_reg, hb_next;
    logic [15:0]          ht_reg, ht_next;
    logic [31:0]          crc_reg, crc_next;
    logic [STAT_W-1:0]    rr_reg, rr_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic                 alloc_reg, alloc_next;
    logic [CNT_W-1:0]     done_reg, done_next;
    logic [ADDR_W-1:0]    bytes_reg, bytes_next;
    logic [ADDR_W-1:0]    base_reg;

    // Combinational working values.
    logic [31:0]          crc_upd;
    logic [POS_W:0]       count;
    logic [POS_W-1:0]     offset;
    logic [CNT_W-1:0]     eff_total;
    logic [LEN_W-1:0]     payload;
    logic [ADDR_W-1:0]    bytes_sum;
    logic                 seen;
    logic                 bm_wr_en;
    logic [BLK_W-1:0]     bm_wr_addr;
    logic                 bm_wr_bit;
    logic [BLK_W-1:0]     bm_rd_addr;

    otabsa_bitmap_ram u_bitmap (
        .aclk    (aclk),
        .wr_en   (bm_wr_en),
        .wr_addr (bm_wr_addr),
        .wr_bit  (bm_wr_bit),
        .rd_addr (bm_rd_addr),
        .rd_bit  (seen)
    );

    assign running   = (state_reg == CTL_RUN);
    assign crc_upd   = otabsa_pkg::crc_byte(crc_reg, in_byte);
    assign count     = {1'b0, pos_reg} + 14'd1;
    assign offset    = pos_reg - OFS_PAYLOAD;
    assign payload   = dl_next - LEN_EMPTY_MAX;
    assign eff_total = alloc_reg ? total_reg : ht_next[CNT_W-1:0];
    assign bytes_sum = bytes_reg + ADDR_W'(payload);

    // The bitmap follows the block id that the header registers will hold next.
    assign bm_rd_addr = hb_next[BLK_W-1:0];

    // Next state and result for the accepted transaction.
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        pos_next     = pos_reg;
        dl_next      = dl_reg;
        hg_next      = hg_reg;
        hm_next      = hm_reg;
        hv_next      = hv_reg;
        hb_next      = hb_reg;
        ht_next      = ht_reg;
        crc_next     = crc_reg;
        rr_next      = rr_reg;
        total_next   = total_reg;
        alloc_next   = alloc_reg;
        done_next    = done_reg;
        bytes_next   = bytes_reg;
        bm_wr_en     = 1'b0;
        bm_wr_addr   = hb_reg[BLK_W-1:0];
        bm_wr_bit    = 1'b1;
        res          = '0;

        // Clearing pass over the bitmap, one entry a cycle.
        if (state_reg == CTL_CLEAR) begin
            bm_wr_en     = 1'b1;
            bm_wr_addr   = clr_cnt_reg;
            bm_wr_bit    = 1'b0;
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == BLK_W'(otabsa_pkg::MAX_BLOCKS - 1)) begin
                state_next = CTL_RUN;
            end
        end

        if (in_accept && in_cmd) begin
            // Start of a new download: drop the partial section and the session, and clear the bitmap.
            pos_next         = '0;
            crc_next         = otabsa_pkg::CRC_INIT;
            rr_next          = otabsa_pkg::STAT_NONE;
            total_next       = '0;
            alloc_next       = 1'b0;
            done_next        = '0;
            bytes_next       = '0;
            state_next       = CTL_CLEAR;
            clr_cnt_next     = '0;
            res.section_done = 1'b1;
            res.status       = otabsa_pkg::STAT_NONE;
        end else if (in_accept) begin
            // Header capture; the first byte also restarts the header fields.
            if (pos_reg == OFS_TABLE) begin
                dl_next = '0;
                hg_next = '0;
                hm_next = '0;
                hv_next = '0;
                hb_next = '0;
                ht_next = '0;
                if (in_byte != otabsa_pkg::TABLE_DDB) begin
                    rr_next = otabsa_pkg::STAT_TABLE;
                end
            end
            case (pos_reg)
                OFS_LEN_HI: dl_next = {in_byte[3:0], 8'h00};
                OFS_LEN_LO: dl_next = dl_reg | {4'h0, in_byte};
                OFS_MODULE: hm_next = in_byte;
                OFS_BLK_HI: hb_next = {in_byte, 8'h00};
                OFS_BLK_LO: hb_next = hb_reg | {8'h00, in_byte};
                OFS_GROUP:  hg_next = in_byte;
                OFS_VER_HI: hv_next = {in_byte, 8'h00};
                OFS_VER_LO: hv_next = hv_reg | {8'h00, in_byte};
                OFS_TOT_HI: ht_next = {in_byte, 8'h00};
                OFS_TOT_LO: ht_next = ht_reg | {8'h00, in_byte};
                default:    ;
            endcase

            // Tentative payload write for a block not yet stored.
            if ((pos_reg >= OFS_PAYLOAD) &&
                (({1'b0, pos_reg} + 14'd1) < {2'b00, dl_reg}) &&
                (rr_reg == otabsa_pkg::STAT_NONE) &&
                ({1'b0, hb_reg} < 17'(otabsa_pkg::MAX_BLOCKS)) &&
                !seen &&
                (offset < POS_W'(otabsa_pkg::BLOCK_STRIDE))) begin
                res.write_enable  = 1'b1;
                res.write_address = base_reg + ADDR_W'(offset);
                res.write_data    = in_byte;
            end

            if (in_last) begin
                // Checks in order of precedence, then the store.
                res.section_done = 1'b1;
                if (rr_next != otabsa_pkg::STAT_NONE) begin
                    res.status = rr_next;
                end else if (({2'b00, dl_next} + 14'd3) != count) begin
                    res.status = otabsa_pkg::STAT_LENGTH;
                end else if ((count < 14'd4) || (crc_upd != 32'h0)) begin
                    res.status = otabsa_pkg::STAT_CRC;
                end else if ((hg_next != cfg.group_id) || (hm_next != cfg.module_id)) begin
                    res.status = otabsa_pkg::STAT_GRPMOD;
                end else if (hv_next != cfg.version) begin
                    res.status = otabsa_pkg::STAT_VERSION;
                end else if (!alloc_reg &&
                             ({1'b0, ht_next} > 17'(otabsa_pkg::MAX_BLOCKS))) begin
                    res.status = otabsa_pkg::STAT_RANGE;
                end else begin
                    if (!alloc_reg) begin
                        alloc_next = 1'b1;
                        total_next = ht_next[CNT_W-1:0];
                        done_next  = '0;
                    end
                    if ((hb_next >= ht_next) || (ht_next > 16'(eff_total))) begin
                        res.status = otabsa_pkg::STAT_RANGE;
                    end else if (seen) begin
                        res.status = otabsa_pkg::STAT_DUP;
                    end else if (dl_next <= LEN_EMPTY_MAX) begin
                        res.status = otabsa_pkg::STAT_EMPTY;
                    end else if (payload > LEN_STRIDE) begin
                        res.status = otabsa_pkg::STAT_TOO_MANY;
                    end else begin
                        bm_wr_en   = 1'b1;
                        bm_wr_addr = hb_next[BLK_W-1:0];
                        bm_wr_bit  = 1'b1;
                        done_next  = done_reg + 1'b1;
                        if ((done_reg + 1'b1) == eff_total) begin
                            bytes_next = bytes_sum - 1'b1;
                            res.status = otabsa_pkg::STAT_COMPLETE;
                        end else begin
                            bytes_next = bytes_sum;
                            res.status = otabsa_pkg::STAT_STORED;
                        end
                    end
                end
                pos_next = '0;
                crc_next = otabsa_pkg::CRC_INIT;
                rr_next  = otabsa_pkg::STAT_NONE;
            end else begin
                crc_next = crc_upd;
                if (pos_reg < otabsa_pkg::POS_MAX) begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end

        res.blocks_done  = done_next;
        res.blocks_total = total_next;
        res.image_size   = bytes_next;
    end

    // Control and session registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CTL_CLEAR;
            clr_cnt_reg <= '0;
            pos_reg     <= '0;
            dl_reg      <= '0;
            hg_reg      <= '0;
            hm_reg      <= '0;
            hv_reg      <= '0;
            hb_reg      <= '0;
            ht_reg      <= '0;
            crc_reg     <= otabsa_pkg::CRC_INIT;
            rr_reg      <= otabsa_pkg::STAT_NONE;
            total_reg   <= '0;
            alloc_reg   <= 1'b0;
            done_reg    <= '0;
            bytes_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pos_reg     <= pos_next;
            dl_reg      <= dl_next;
            hg_reg      <= hg_next;
            hm_reg      <= hm_next;
            hv_reg      <= hv_next;
            hb_reg      <= hb_next;
            ht_reg      <= ht_next;
            crc_reg     <= crc_next;
            rr_reg      <= rr_next;
            total_reg   <= total_next;
            alloc_reg   <= alloc_next;
            done_reg    <= done_next;
            bytes_reg   <= bytes_next;
        end
    end

    // Block base address, ready long before the first payload byte.
    always_ff @(posedge aclk) begin
        base_reg <= ADDR_W'(hb_reg[BLK_W-1:0]) * ADDR_W'(otabsa_pkg::BLOCK_STRIDE);
    end

endmodule

// ===== hw/rtl/otabsa_out_skid.sv =====
// Output register with a skid stage between the result and the downstream channel.
module otabsa_out_skid (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  otabsa_pkg::res_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output otabsa_pkg::res_t out_data
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    otabsa_pkg::res_t main_reg;
    otabsa_pkg::res_t skid_reg;
    logic             in_acc;
    logic             main_free;

    assign in_ready  = !skid_valid_reg;
    assign in_acc    = in_valid && in_ready;
    assign main_free = !main_valid_reg || out_ready;

    // Valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (main_free) begin
                main_valid_reg <= skid_valid_reg || in_acc;
                skid_valid_reg <= 1'b0;
            end else if (in_acc) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (main_free) begin
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        end
        if (in_acc && !main_free) begin
            skid_reg <= in_data;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule
